FILE: rtl/core/cgmp_pkg.sv
// ----------------------------------------------------------------------------
// cgmp_pkg - shared types and constants for the cyclic grid minimum path block
// Sizes of the grid, field widths and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package cgmp_pkg;

  localparam int MAX_ROWS = 16;
  localparam int MAX_COLS = 64;
  localparam int CELLS    = MAX_ROWS * MAX_COLS;

  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int ROWS_W  = 5;
  localparam int COLS_W  = 7;
  localparam int CNT_W   = ADDR_W + 1;
  localparam int WGT_W   = 31;
  localparam int COST_W  = 37;
  localparam int PAR_W   = MAX_ROWS * ROW_W;

  localparam int REG_ROWS = 0;
  localparam int REG_COLS = 1;

  typedef logic signed [WGT_W-1:0]  weight_t;
  typedef logic signed [COST_W-1:0] cost_t;
  typedef logic [ROW_W-1:0]         row_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FILL,
    ST_UPDATE,
    ST_SCAN,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_t;

  // control handed to every cell in the chain
  typedef struct packed {
    logic shift_en;
    logic update_en;
    logic first_col;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/cgmp_cell.sv
// ----------------------------------------------------------------------------
// cgmp_cell - one row of the cost chain
// Holds the row's weight and running cost, picks the cheapest successor.
// ----------------------------------------------------------------------------
`default_nettype none

module cgmp_cell (
  input  wire                   clk,
  input  wire cgmp_pkg::cell_ctrl_t ctrl,
  input  wire cgmp_pkg::weight_t    w_in,
  input  wire cgmp_pkg::row_t       row_idx,
  input  wire cgmp_pkg::row_t       up_idx,
  input  wire cgmp_pkg::row_t       dn_idx,
  input  wire cgmp_pkg::cost_t      up_cost,
  input  wire cgmp_pkg::cost_t      dn_cost,
  output cgmp_pkg::weight_t     w_out,
  output cgmp_pkg::cost_t       cost,
  output cgmp_pkg::row_t        parent
);
  import cgmp_pkg::*;

  weight_t w_r;
  cost_t   cost_r;
  cost_t   best_a;
  row_t    idx_a;
  cost_t   best_b;
  row_t    idx_b;

  // candidates in order up, self, down; lower row index wins a tie
  always_comb begin
    best_a = up_cost;
    idx_a  = up_idx;
    if ((cost_r < best_a) || ((cost_r == best_a) && (row_idx < idx_a))) begin
      best_a = cost_r;
      idx_a  = row_idx;
    end
    best_b = best_a;
    idx_b  = idx_a;
    if ((dn_cost < best_b) || ((dn_cost == best_b) && (dn_idx < idx_b))) begin
      best_b = dn_cost;
      idx_b  = dn_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift_en) begin
      w_r <= w_in;
    end
    if (ctrl.update_en) begin
      if (ctrl.first_col) begin
        cost_r <= COST_W'(w_r);
      end else begin
        cost_r <= best_b + COST_W'(w_r);
      end
    end
  end

  assign w_out  = w_r;
  assign cost   = cost_r;
  assign parent = idx_b;

endmodule

`default_nettype wire

FILE: rtl/core/cyclic_grid_min_path.sv
// ----------------------------------------------------------------------------
// cyclic_grid_min_path - minimum weight left-to-right path through a cyclic grid
// Loads a grid of weights, runs a backward column sweep, streams the path.
// ----------------------------------------------------------------------------
// Weights arrive one request per cycle in row-major order, grid_rows * grid_cols
// of them, and are kept in a 1024-entry weight RAM. While loading the block
// takes one request per cycle. The request carrying the last weight starts the
// sweep: for each column, from the last back to the first, the weights of that
// column are read one row per cycle and shifted into a chain of MAX_ROWS cells,
// then all cells update together, each taking the cheapest of its three
// neighbours (rows wrap) with ties going to the lower row, and the chosen rows
// of the column are written as one word into the parent RAM. A scan over the
// rows then picks the start row. Finally the path is emitted, one result per
// column, each a parent RAM read and then an output, each result carrying the
// total cost and the final one flagged last. Writing either register drops a
// partly loaded grid. Register values out of range are saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module cyclic_grid_min_path (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       psel,
  input  wire                       penable,
  input  wire                       pwrite,
  input  wire  [2:0]                paddr,
  input  wire  [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire cgmp_pkg::weight_t    in_cell_weight,
  output logic                      out_valid,
  input  wire                       out_stall,
  output logic [cgmp_pkg::ROW_W-1:0] out_path_row,
  output cgmp_pkg::cost_t           out_path_cost,
  output logic                      out_last_of_path
);
  import cgmp_pkg::*;

  // configuration
  logic [ROWS_W-1:0] rows_r;
  logic [COLS_W-1:0] cols_r;
  logic [ADDR_W-1:0] rowbase_r;   // (rows-1) * cols
  logic              cfg_wr;

  // sequencer
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  load_cnt_r, load_cnt_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [ROWS_W-1:0] iss_r, iss_nxt;
  logic [ROWS_W-1:0] rcv_r, rcv_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic [ROWS_W-1:0] scan_r, scan_nxt;
  cost_t             best_r, best_nxt;
  row_t              nx_r, nx_nxt;

  // memories
  weight_t           wmem [CELLS];
  logic [PAR_W-1:0]  pmem [MAX_COLS];
  weight_t           wq_r;
  logic [PAR_W-1:0]  pq_r;
  logic              in_acc;
  logic              w_rd_en;
  logic              p_wr_en;
  logic              p_rd_en;

  // output register
  logic              out_valid_r, out_valid_nxt;
  row_t              out_row_r, out_row_nxt;
  cost_t             out_cost_r, out_cost_nxt;
  logic              out_last_r, out_last_nxt;

  // cell chain
  cell_ctrl_t        ctrl;
  weight_t           w_chain [MAX_ROWS+1];
  cost_t             cost_v [MAX_ROWS];
  row_t              par_v [MAX_ROWS];
  logic [PAR_W-1:0]  par_word;
  row_t              last_row;

  assign last_row = ROW_W'(rows_r - ROWS_W'(1));

  // --------------------------------------------------------------------------
  // configuration port: saturate on write, drop any partial grid
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= ROWS_W'(1);
      cols_r <= COLS_W'(1);
    end else if (cfg_wr) begin
      if (paddr[2] == 1'(REG_ROWS)) begin
        if (pwdata[ROWS_W-1:0] == '0) begin
          rows_r <= ROWS_W'(1);
        end else if (pwdata[ROWS_W-1:0] > ROWS_W'(MAX_ROWS)) begin
          rows_r <= ROWS_W'(MAX_ROWS);
        end else begin
          rows_r <= pwdata[ROWS_W-1:0];
        end
      end else begin
        if (pwdata[COLS_W-1:0] == '0) begin
          cols_r <= COLS_W'(1);
        end else if (pwdata[COLS_W-1:0] > COLS_W'(MAX_COLS)) begin
          cols_r <= COLS_W'(MAX_COLS);
        end else begin
          cols_r <= pwdata[COLS_W-1:0];
        end
      end
    end
  end

  always_comb begin
    if (paddr[2] == 1'(REG_ROWS)) begin
      prdata = 32'(rows_r);
    end else begin
      prdata = 32'(cols_r);
    end
  end

  // small product, held in a register for the address path
  always_ff @(posedge clk) begin
    rowbase_r <= ADDR_W'(32'(last_row) * 32'(cols_r));
  end

  // --------------------------------------------------------------------------
  // cell chain: weights enter at cell 0 and advance one row per shift
  // --------------------------------------------------------------------------
  assign w_chain[0] = wq_r;

  for (genvar g = 0; g < MAX_ROWS; g++) begin : g_cell
    row_t  up_i, dn_i;
    cost_t up_c, dn_c;

    always_comb begin
      if (ROW_W'(g) == row_t'(0)) begin
        up_i = last_row;
      end else begin
        up_i = ROW_W'(g - 1);
      end
      if (ROW_W'(g) == last_row) begin
        dn_i = '0;
      end else begin
        dn_i = ROW_W'(g + 1);
      end
      up_c = cost_v[up_i];
      dn_c = cost_v[dn_i];
    end

    cgmp_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .w_in    (w_chain[g]),
      .row_idx (ROW_W'(g)),
      .up_idx  (up_i),
      .dn_idx  (dn_i),
      .up_cost (up_c),
      .dn_cost (dn_c),
      .w_out   (w_chain[g+1]),
      .cost    (cost_v[g]),
      .parent  (par_v[g])
    );

    assign par_word[g*ROW_W +: ROW_W] = par_v[g];
  end

  // --------------------------------------------------------------------------
  // memories
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      wmem[load_cnt_r[ADDR_W-1:0]] <= in_cell_weight;
    end
    if (w_rd_en) begin
      wq_r <= wmem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (p_wr_en) begin
      pmem[col_r] <= par_word;
    end
    if (p_rd_en) begin
      pq_r <= pmem[col_r];
    end
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      load_cnt_r  <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r      <= col_nxt;
    addr_r     <= addr_nxt;
    iss_r      <= iss_nxt;
    rcv_r      <= rcv_nxt;
    scan_r     <= scan_nxt;
    best_r     <= best_nxt;
    nx_r       <= nx_nxt;
    out_row_r  <= out_row_nxt;
    out_cost_r <= out_cost_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    load_cnt_nxt  = load_cnt_r;
    col_nxt       = col_r;
    addr_nxt      = addr_r;
    iss_nxt       = iss_r;
    rcv_nxt       = rcv_r;
    rd_pend_nxt   = 1'b0;
    scan_nxt      = scan_r;
    best_nxt      = best_r;
    nx_nxt        = nx_r;
    out_valid_nxt = out_valid_r;
    out_row_nxt   = out_row_r;
    out_cost_nxt  = out_cost_r;
    out_last_nxt  = out_last_r;
    in_stall      = 1'b1;
    in_acc        = 1'b0;
    w_rd_en       = 1'b0;
    p_wr_en       = 1'b0;
    p_rd_en       = 1'b0;
    ctrl          = '0;

    // drop a delivered result
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_LOAD: begin
        in_stall = 1'b0;
        in_acc   = in_valid;
        if (in_valid) begin
          if ((load_cnt_r + CNT_W'(1)) ==
              CNT_W'(32'(rows_r) * 32'(cols_r))) begin
            load_cnt_nxt = '0;
            col_nxt      = COL_W'(cols_r - COLS_W'(1));
            addr_nxt     = rowbase_r + ADDR_W'(cols_r - COLS_W'(1));
            iss_nxt      = '0;
            rcv_nxt      = '0;
            state_nxt    = ST_FILL;
          end else begin
            load_cnt_nxt = load_cnt_r + CNT_W'(1);
          end
        end
      end

      ST_FILL: begin
        // issue reads from the bottom row up, so row r lands in cell r
        if (iss_r != rows_r) begin
          w_rd_en     = 1'b1;
          rd_pend_nxt = 1'b1;
          iss_nxt     = iss_r + ROWS_W'(1);
          addr_nxt    = addr_r - ADDR_W'(cols_r);
        end
        if (rd_pend_r) begin
          ctrl.shift_en = 1'b1;
          rcv_nxt       = rcv_r + ROWS_W'(1);
          if (rcv_r == ROWS_W'(last_row)) begin
            state_nxt = ST_UPDATE;
          end
        end
      end

      ST_UPDATE: begin
        ctrl.update_en = 1'b1;
        ctrl.first_col = (COLS_W'(col_r) == (cols_r - COLS_W'(1)));
        p_wr_en        = 1'b1;
        if (col_r == '0) begin
          scan_nxt  = ROWS_W'(1);
          state_nxt = ST_SCAN;
        end else begin
          col_nxt   = col_r - COL_W'(1);
          addr_nxt  = rowbase_r + ADDR_W'(col_r) - ADDR_W'(1);
          iss_nxt   = '0;
          rcv_nxt   = '0;
          state_nxt = ST_FILL;
        end
        // prime the start-row scan with row 0
        best_nxt = (ctrl.first_col) ? COST_W'(w_chain[1]) : best_r;
        nx_nxt   = '0;
      end

      ST_SCAN: begin
        if (scan_r == ROWS_W'(1)) begin
          best_nxt = cost_v[0];
          nx_nxt   = '0;
        end
        if (scan_r < rows_r) begin
          if (scan_r == ROWS_W'(1)) begin
            if (cost_v[scan_r[ROW_W-1:0]] < cost_v[0]) begin
              best_nxt = cost_v[scan_r[ROW_W-1:0]];
              nx_nxt   = scan_r[ROW_W-1:0];
            end
          end else if (cost_v[scan_r[ROW_W-1:0]] < best_r) begin
            best_nxt = cost_v[scan_r[ROW_W-1:0]];
            nx_nxt   = scan_r[ROW_W-1:0];
          end
          scan_nxt = scan_r + ROWS_W'(1);
        end else begin
          col_nxt   = '0;
          state_nxt = ST_EMIT_RD;
        end
      end

      ST_EMIT_RD: begin
        p_rd_en   = 1'b1;
        state_nxt = ST_EMIT_OUT;
      end

      ST_EMIT_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = nx_r;
          out_cost_nxt  = best_r;
          out_last_nxt  = (COLS_W'(col_r) == (cols_r - COLS_W'(1)));
          nx_nxt        = pq_r[nx_r*ROW_W +: ROW_W];
          col_nxt       = col_r + COL_W'(1);
          if (COLS_W'(col_r) == (cols_r - COLS_W'(1))) begin
            state_nxt = ST_LOAD;
          end else begin
            state_nxt = ST_EMIT_RD;
          end
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase

    // a register write drops a partly loaded grid
    if (cfg_wr) begin
      load_cnt_nxt = '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_path_row     = out_row_r;
  assign out_path_cost    = out_cost_r;
  assign out_last_of_path = out_last_r;

endmodule

`default_nettype wire

FILE: dv/tb_cyclic_grid_min_path.sv
// ----------------------------------------------------------------------------
// tb_cyclic_grid_min_path - self-checking bench for the cyclic grid path block
// Loads random and directed grids under several register settings, predicts
// the minimum path of every complete grid and checks each step's row, cost and last flag in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_cyclic_grid_min_path;
  import cgmp_pkg::*;

  // one expected path step
  typedef struct {
    row_t  row;
    cost_t cost;
    logic  last;
  } path_step_t;

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  weight_t     in_cell_weight;
  logic        out_valid;
  logic        out_stall;
  row_t        out_path_row;
  cost_t       out_path_cost;
  logic        out_last_of_path;

  cyclic_grid_min_path u_dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_cell_weight(in_cell_weight),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_path_row(out_path_row), .out_path_cost(out_path_cost),
    .out_last_of_path(out_last_of_path)
  );

  // predictor state: its own copy of the registers and the grid
  int unsigned n_rows = 1;
  int unsigned n_cols = 1;
  int unsigned weights_held = 0;
  longint      grid_wgt [CELLS];

  weight_t     weight_queue [$];  // pending requests for the driver
  path_step_t  path_expected [$]; // predicted results, oldest first
  int          fail_count = 0;
  int          requests_taken = 0;
  bit          stall_bursty = 1;

  int  gap_left = 0;
  logic in_stall_q = 1'b0;

  int shapes [8][2] = '{'{1, 1}, '{16, 1}, '{1, 64}, '{3, 4}, '{2, 5},
                        '{4, 3}, '{5, 6}, '{16, 2}};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    fail_count++;
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Work out the minimum path for the grid now held and queue its steps.
  task automatic predict_path();
    longint nxt [MAX_ROWS];
    longint cur [MAX_ROWS];
    int     succ [MAX_ROWS*MAX_COLS];
    int     cand [3];
    int     best, start, nx;
    longint total;
    path_step_t s;
    for (int r = 0; r < n_rows; r++) nxt[r] = grid_wgt[r*n_cols + n_cols - 1];
    for (int c = int'(n_cols) - 2; c >= 0; c--) begin
      for (int r = 0; r < n_rows; r++) begin
        cand[0] = (r == 0) ? n_rows - 1 : r - 1;
        cand[1] = r;
        cand[2] = (r + 1 == n_rows) ? 0 : r + 1;
        best = cand[0];
        for (int k = 1; k < 3; k++)
          if (nxt[cand[k]] < nxt[best] || (nxt[cand[k]] == nxt[best] && cand[k] < best))
            best = cand[k];
        cur[r] = nxt[best] + grid_wgt[r*n_cols + c];
        succ[r*MAX_COLS + c] = best;
      end
      for (int r = 0; r < n_rows; r++) nxt[r] = cur[r];
    end
    start = 0;
    for (int r = 1; r < n_rows; r++) if (nxt[r] < nxt[start]) start = r;
    total = nxt[start];
    nx = start;
    for (int c = 0; c < n_cols; c++) begin
      s.row  = row_t'(nx);
      s.cost = cost_t'(total);
      s.last = (c + 1 == n_cols);
      path_expected.push_back(s);
      if (c + 1 < n_cols) nx = succ[nx*MAX_COLS + c];
    end
  endtask

  // Driver: present a request at the falling edge, hold it while stalled.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall_q) begin
        void'(weight_queue.pop_front());
      end
      if ((!in_valid || !in_stall_q) ) begin
        if (weight_queue.size() > 0 && gap_left == 0) begin
          in_valid       <= 1'b1;
          in_cell_weight <= weight_queue[0];
          gap_left       <= pick_gap();
        end else begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end
      end
      out_stall <= (stall_bursty && $urandom_range(0, 99) < 30) ? 1'b1 :
                   ($urandom_range(0, 199) == 0);
    end
  end

  // Monitor: take requests and results at the rising edge.
  always @(posedge clk) begin
    path_step_t e;
    in_stall_q <= in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        requests_taken++;
        grid_wgt[weights_held] = in_cell_weight;
        weights_held++;
        if (weights_held == n_rows * n_cols) begin
          weights_held = 0;
          predict_path();
        end
      end
      if (out_valid && !out_stall) begin
        if (path_expected.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          e = path_expected.pop_front();
          if (out_path_row !== e.row)
            report_mismatch($sformatf("path_row %0d, want %0d", out_path_row, e.row));
          if (out_path_cost !== e.cost)
            report_mismatch($sformatf("path_cost %0d, want %0d", out_path_cost, e.cost));
          if (out_last_of_path !== e.last)
            report_mismatch($sformatf("last_of_path %0b, want %0b", out_last_of_path, e.last));
        end
      end
    end
  end

  // APB register write: setup cycle, then access cycle.
  task automatic write_reg(input int idx, input int unsigned value);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'(4 * idx); pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    // mirror the saturation the block applies on write
    if (idx == REG_ROWS)
      n_rows = ((value & 32'h1F) < 1) ? 1 : ((value & 32'h1F) > MAX_ROWS) ? MAX_ROWS : value & 32'h1F;
    else if (idx == REG_COLS)
      n_cols = ((value & 32'h7F) < 1) ? 1 : ((value & 32'h7F) > MAX_COLS) ? MAX_COLS : value & 32'h7F;
    weights_held = 0;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Wait until every request is taken and every path step has arrived.
  task automatic drain();
    while (weight_queue.size() != 0 || in_valid) @(posedge clk);
    while (path_expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic weight_t rand_weight(input int mode);
    case (mode)
      0: return weight_t'($urandom);
      1: return weight_t'(int'($urandom_range(0, 6)) - 3);
      default: return ($urandom_range(0, 1)) ? 31'sh3FFFFFFF : 31'sh40000000;
    endcase
  endfunction

  // Queue one whole grid at the current sizes.
  task automatic queue_grid(input int mode);
    for (int i = 0; i < n_rows * n_cols; i++) weight_queue.push_back(rand_weight(mode));
  endtask

  initial begin
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid = 0; in_cell_weight = '0; out_stall = 0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset sizes give a single cell; extremes and ties follow.
    weight_queue.push_back(31'sh3FFFFFFF);
    weight_queue.push_back(31'sh40000000);
    drain();
    write_reg(REG_ROWS, 3); write_reg(REG_COLS, 2);
    repeat (6) weight_queue.push_back('0);  // all tied: lowest rows win
    weight_queue.push_back(31'sh40000000);  // partial grid, dropped by the write below
    drain();
    write_reg(REG_ROWS, 0);                 // saturates up to one row
    write_reg(REG_COLS, 127);               // saturates down to 64
    queue_grid(2);
    drain();
    write_reg(REG_ROWS, 31); write_reg(REG_COLS, 1);
    queue_grid(1);
    drain();
    write_reg(REG_ROWS, 16); write_reg(REG_COLS, 4);
    queue_grid(1);
    drain();

    // Random: mostly small grids, a few walk through the largest shapes.
    while (requests_taken < 385) begin
      int k;
      k = $urandom_range(0, 7);
      write_reg(REG_ROWS, shapes[k][0] + $urandom_range(0, 1));
      write_reg(REG_COLS, shapes[k][1] + $urandom_range(0, 1));
      stall_bursty = $urandom_range(0, 3) != 0;
      repeat ($urandom_range(1, 2)) queue_grid($urandom_range(0, 2));
      drain();
    end

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
